FILE: design/fbcd_pkg.sv
`default_nettype none
package fbcd_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int FILE_W      = 16;
  localparam int OFF_W       = 48;
  localparam int SLOT_OUT_W  = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [FILE_W-1:0] file_id;
    logic [OFF_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [FILE_W-1:0]     evicted_file_id;
    logic [OFF_W-1:0]      evicted_offset;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVRD,
    ST_INSERT,
    ST_DONE
  } fbcd_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic ev_read;
    logic ins_write;
    logic res_hit;
    logic res_miss;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic match;
    logic scan_end;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/fbcd_datapath.sv
`default_nettype none
module fbcd_datapath #(
  parameter int ENTRIES = fbcd_pkg::DEF_ENTRIES
) (
  input  wire               clk,
  input  wire               rst_n,
  input  fbcd_pkg::req_t    in_data,
  input  fbcd_pkg::ctrl_cmd_t cmd,
  output fbcd_pkg::dp_stat_t  stat,
  output logic              out_valid,
  input  wire               out_ready,
  output fbcd_pkg::rsp_t    out_data
);
  import fbcd_pkg::*;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int KEY_W  = FILE_W + OFF_W;

  logic [KEY_W-1:0] mem [ENTRIES];

  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [KEY_W-1:0]  rd_data_r;
  logic [SLOT_W-1:0] rd_slot_r;
  req_t              req_r;
  rsp_t              res_r;
  rsp_t              out_data_r;

  logic              full;
  logic              more;
  logic [KEY_W-1:0]  key_req;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail_wrap;
  logic [SLOT_W-1:0] ins_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_en;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    if (s == SLOT_W'(ENTRIES - 1)) begin
      n = '0;
    end else begin
      n = s + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOT_OUT_W-1:0] w;
    w = {{SLOT_OUT_W{1'b0}}, s};
    return w[SLOT_OUT_W-1:0];
  endfunction

  assign full    = (count_r == CNT_W'(ENTRIES));
  assign more    = (k_r < count_r);
  assign key_req = {req_r.file_id, req_r.block_offset};

  // tail slot, oldest + count stays below twice the depth
  assign tail_sum  = SUM_W'(oldest_r) + SUM_W'(count_r);
  assign tail_wrap = (tail_sum >= SUM_W'(ENTRIES)) ? (tail_sum - SUM_W'(ENTRIES)) : tail_sum;
  assign ins_slot  = full ? oldest_r : tail_wrap[SLOT_W-1:0];

  assign rd_addr = cmd.ev_read ? oldest_r : ptr_r;
  assign rd_en   = cmd.ev_read || (cmd.scan_step && more);

  assign stat.full     = full;
  assign stat.match    = rd_vld_r && (rd_data_r == key_req);
  assign stat.scan_end = !rd_vld_r && !more;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    rd_vld_nxt    = cmd.scan_step && more;
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      ptr_nxt = oldest_r;
      k_nxt   = '0;
    end
    if (cmd.scan_step && more) begin
      ptr_nxt = next_slot(ptr_r);
      k_nxt   = k_r + 1'b1;
    end
    if (cmd.ins_write) begin
      if (full) begin
        oldest_nxt = next_slot(oldest_r);
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // tag memory, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_slot_r <= rd_addr;
    end
    if (cmd.ins_write) begin
      mem[ins_slot] <= key_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.res_hit) begin
      res_r <= '{1'b1, slot_out(rd_slot_r), 1'b0, '0, '0};
    end else if (cmd.res_miss) begin
      res_r <= '0;
    end else if (cmd.ins_write) begin
      res_r <= '{1'b0, slot_out(ins_slot), full,
                 full ? rd_data_r[KEY_W-1:OFF_W] : '0,
                 full ? rd_data_r[OFF_W-1:0] : '0};
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: design/fbcd_ctrl.sv
`default_nettype none
module fbcd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_op,
  output logic                in_ready,
  input  fbcd_pkg::dp_stat_t  stat,
  output fbcd_pkg::ctrl_cmd_t cmd
);
  import fbcd_pkg::*;

  fbcd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_INSERT) begin
            state_nxt = stat.full ? ST_EVRD : ST_INSERT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.match || stat.scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_EVRD:   state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_SCAN: begin
        if (stat.match) begin
          cmd.res_hit = 1'b1;
        end else if (stat.scan_end) begin
          cmd.res_miss = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EVRD:   cmd.ev_read = 1'b1;
      ST_INSERT: cmd.ins_write = 1'b1;
      ST_DONE:   cmd.out_load = stat.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/fifo_block_cache_directory_unit.sv
`default_nettype none
// fifo replacement tag directory for a block cache of ENTRIES slots. each input word is a
// lookup (op 0) or an insert (op 1) keyed by file_id and block_offset; each produces exactly
// one result word. a lookup walks the valid entries from oldest to newest, one tag memory
// read per cycle, and reports the oldest match; a miss walks all valid entries, at most
// ENTRIES, and a lookup in an empty directory reads none. when the cache is full, an insert
// first reads the head entry out for write-back; that entry's key comes back in
// evicted_file_id/evicted_offset and its slot is reused. a blocked output register delays
// the next accept. the single read port of the tag memory sets the scan rate. one word is
// in flight at a time; a finished result waits in the output register while the next
// word is accepted. tags need no clearing after reset, only valid entries are compared.
module fifo_block_cache_directory_unit #(
  parameter int ENTRIES = fbcd_pkg::DEF_ENTRIES
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  fbcd_pkg::req_t in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output fbcd_pkg::rsp_t out_data
);
  import fbcd_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fbcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tag memory, fifo pointers, scan and result registers
  fbcd_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // one word in flight: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while previous word in flight");

  // a result load always shows up at the output
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  // no eviction means zero write-back key
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.evicted) |->
      (out_data.evicted_file_id == '0 && out_data.evicted_offset == '0))
    else $error("write-back key set without eviction");

  // a hit is never an eviction
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> !out_data.evicted)
    else $error("hit and eviction in one result");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
module tb;
  import fbcd_pkg::*;

  localparam int NSLOT    = DEF_ENTRIES;
  localparam int N_RANDOM = 1150;
  localparam int POOL_N   = 20;
  // longest single word: full miss scan plus capture and output
  localparam int SETTLE   = NSLOT + 8;
  localparam int HOLD_CYC = 250;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_t;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  fifo_block_cache_directory_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // directory shadow: tags, head of the fifo and fill level
  // ---------------------------------------------------------------
  logic [FILE_W-1:0] dir_file[NSLOT];
  logic [OFF_W-1:0]  dir_off[NSLOT];
  int unsigned       dir_head;
  int unsigned       dir_count;

  // expected result words, oldest first
  rsp_t pending_rsp[$];

  int fail_count;
  int n_checked;
  int n_lookup;
  int n_insert;
  int n_hit;
  int n_evict;

  // sender burst shaping
  int burst_left;
  int gap;

  // long receiver hold-off, requested by the stimulus and counted by the receiver
  int hold_asks;
  int hold_asks_q;
  int hold_seen = 0;
  int hold_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  // one lookup or insert against the shadow directory, returns the expected word
  function automatic rsp_t dir_predict(input req_t r);
    rsp_t        p;
    int unsigned k;
    int unsigned s;
    p = '0;
    if (r.op == OP_LOOKUP) begin
      // oldest to newest, first match wins
      for (k = 0; k < dir_count && !p.hit; k++) begin
        s = (dir_head + k) % NSLOT;
        if (dir_file[s] == r.file_id && dir_off[s] == r.block_offset) begin
          p.hit  = 1'b1;
          p.slot = SLOT_OUT_W'(s);
        end
      end
    end else begin
      if (dir_count >= NSLOT) begin
        // full: head entry goes out for write-back, its slot is reused
        s                 = dir_head;
        p.evicted         = 1'b1;
        p.evicted_file_id = dir_file[s];
        p.evicted_offset  = dir_off[s];
        dir_head          = (dir_head + 1) % NSLOT;
      end else begin
        s         = (dir_head + dir_count) % NSLOT;
        dir_count = dir_count + 1;
      end
      dir_file[s] = r.file_id;
      dir_off[s]  = r.block_offset;
      p.slot      = SLOT_OUT_W'(s);
    end
    return p;
  endfunction

  function automatic req_t mk_req(input logic op, input logic [FILE_W-1:0] f,
                                  input logic [OFF_W-1:0] o);
    req_t r;
    r.op           = op;
    r.file_id      = f;
    r.block_offset = o;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic h, input logic [SLOT_OUT_W-1:0] s,
                                  input logic ev, input logic [FILE_W-1:0] ef,
                                  input logic [OFF_W-1:0] eo);
    rsp_t p;
    p.hit             = h;
    p.slot            = s;
    p.evicted         = ev;
    p.evicted_file_id = ef;
    p.evicted_offset  = eo;
    return p;
  endfunction

  // random key parts, with the field extremes mixed in now and then
  function automatic logic [FILE_W-1:0] rand_fid();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return {FILE_W{1'b1}};
      default: return FILE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] rand_off();
    logic [63:0] t;
    t = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return OFF_MAX;
      default: return t[OFF_W-1:0];
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("mismatch at %0t, result %0d: %s got %0h expected %0h",
             $time, n_checked, what, got, want);
  endtask

  // offer one word, wait for the handshake, then queue its expected result.
  // called and returning at a falling edge; valid stays up inside a burst
  task automatic send_word(input req_t r, input bit typed, input rsp_t want);
    rsp_t p;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    p = dir_predict(r);
    if (typed)
      p = want;
    pending_rsp.push_back(p);
    if (r.op == OP_LOOKUP)
      n_lookup++;
    else
      n_insert++;
    if (p.hit)
      n_hit++;
    if (p.evicted)
      n_evict++;
    burst_left--;
    @(negedge clk);
  endtask

  // sender goes quiet until every queued result is back, plus a settle time
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------
  // receiver: own stall pattern, switched to a random mode whenever its run ends,
  // plus the long hold-off when the stimulus asks for it
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    hold_asks_q <= hold_asks;
  end

  always @(negedge clk) begin
    if (hold_asks_q != hold_seen) begin
      hold_seen = hold_asks_q;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------
  // result checker: every accepted word against the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result word with nothing pending", 64'(out_data.slot), '0);
      end else begin
        e = pending_rsp.pop_front();
        if (out_data.hit !== e.hit)
          report_mismatch("hit", 64'(out_data.hit), 64'(e.hit));
        if (out_data.slot !== e.slot)
          report_mismatch("slot", 64'(out_data.slot), 64'(e.slot));
        if (out_data.evicted !== e.evicted)
          report_mismatch("evicted", 64'(out_data.evicted), 64'(e.evicted));
        if (out_data.evicted_file_id !== e.evicted_file_id)
          report_mismatch("evicted_file_id", 64'(out_data.evicted_file_id),
                          64'(e.evicted_file_id));
        if (out_data.evicted_offset !== e.evicted_offset)
          report_mismatch("evicted_offset", 64'(out_data.evicted_offset),
                          64'(e.evicted_offset));
      end
      n_checked++;
    end
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("timeout: %0d result words still pending", pending_rsp.size());
    $display("** fifo_block_cache_directory_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  initial begin
    dir_row_t          dir_rows[$];
    req_t              r;
    int                i;
    int                k;
    int                j;
    int                pick;
    logic [FILE_W-1:0] pool_fid[POOL_N];
    logic [OFF_W-1:0]  pool_off[POOL_N];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    dir_head  = 0;
    dir_count = 0;
    hold_asks = 0;

    // directed table: empty directory, key extremes, duplicates, wrap with eviction
    // empty directory misses on any key
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'hffff, OFF_MAX), 1'b1, mk_rsp(0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'h0000, '0), 1'b1, mk_rsp(0, 0, 0, 0, 0)});
    // first inserts land in order from slot 0
    dir_rows.push_back('{mk_req(OP_INSERT, 16'h0000, '0), 1'b1, mk_rsp(0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(OP_INSERT, 16'hffff, OFF_MAX), 1'b1, mk_rsp(0, 1, 0, 0, 0)});
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'h0000, '0), 1'b1, mk_rsp(1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'hffff, OFF_MAX), 1'b1, mk_rsp(1, 1, 0, 0, 0)});
    // duplicate key gets its own slot, lookup still reports the oldest copy
    dir_rows.push_back('{mk_req(OP_INSERT, 16'h0000, '0), 1'b1, mk_rsp(0, 2, 0, 0, 0)});
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'h0000, '0), 1'b1, mk_rsp(1, 0, 0, 0, 0)});
    // file matches but offset does not
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'h0000, OFF_MAX), 1'b1, mk_rsp(0, 0, 0, 0, 0)});
    // fill up the remaining slots, walking offset bits
    for (k = 0; k < NSLOT - 3; k++)
      dir_rows.push_back('{mk_req(OP_INSERT, FILE_W'(16'h0100 + k), 48'h1 << (3 * k + 1)),
                           1'b0, mk_rsp(0, 0, 0, 0, 0)});
    // full: head entries leave for write-back, their slots are reused
    dir_rows.push_back('{mk_req(OP_INSERT, 16'h5a5a, 48'h0000_a5a5_0000), 1'b1,
                         mk_rsp(0, 0, 1, 16'h0000, '0)});
    dir_rows.push_back('{mk_req(OP_INSERT, 16'h00ff, 48'hff00_ff00_ff00), 1'b1,
                         mk_rsp(0, 1, 1, 16'hffff, OFF_MAX)});
    // surviving duplicate is now the head
    dir_rows.push_back('{mk_req(OP_LOOKUP, 16'h0000, '0), 1'b1, mk_rsp(1, 2, 0, 0, 0)});

    for (j = 0; j < POOL_N; j++) begin
      pool_fid[j] = rand_fid();
      pool_off[j] = rand_off();
    end

    // reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    burst_left = 0;
    foreach (dir_rows[i])
      send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // random part: mostly keys from a small pool so lookups hit and duplicates pile up,
    // with near misses on one flipped bit and fully random keys as noise
    for (i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      j    = $urandom_range(0, POOL_N - 1);
      r.op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
      if (pick < 60) begin
        r.file_id      = pool_fid[j];
        r.block_offset = pool_off[j];
      end else if (pick < 72) begin
        r.file_id      = pool_fid[j];
        r.block_offset = pool_off[j] ^ (48'h1 << $urandom_range(0, OFF_W - 1));
      end else if (pick < 78) begin
        r.file_id      = pool_fid[j] ^ (16'h1 << $urandom_range(0, FILE_W - 1));
        r.block_offset = pool_off[j];
      end else begin
        r.file_id      = rand_fid();
        r.block_offset = rand_off();
      end
      // slowly turn the pool over so old keys age out of the directory
      if (r.op == OP_INSERT && $urandom_range(0, 9) == 0) begin
        pool_fid[j] = rand_fid();
        pool_off[j] = rand_off();
      end
      send_word(r, 1'b0, '0);
      // long receiver stall while the sender keeps pushing
      if (i == 300 || i == 850)
        hold_asks++;
      // sender stops until the block is empty
      if (i == 600)
        drain_results();
    end

    in_valid <= 1'b0;
    while (pending_rsp.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d result words: %0d lookups with %0d hits, %0d inserts",
             n_checked, n_lookup, n_hit, n_insert);
    $display("%0d inserts evicted the head entry for write-back, %0d mismatches",
             n_evict, fail_count);
    if (fail_count == 0)
      $display("** fifo_block_cache_directory_unit: PASSED **");
    else
      $display("** fifo_block_cache_directory_unit: FAILED **");
    $finish;
  end

endmodule
